// ===== rtl/tcc_pkg.sv =====
// Package for the tilt-compensated compass: widths, CORDIC constants,
// shared types and the CORDIC step functions.
// No dependencies.
`default_nettype none

package tcc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FIELD_W      = 16;
    localparam int OFF_W        = 16;
    localparam int TAB_LEN      = 24;
    localparam int TI_W         = $clog2(TAB_LEN);
    localparam int STEPS        = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    // sample widths
    localparam int WIDE_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int ACC_W  = SAMPLE_BITS + 8;
    localparam int MAG_W  = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W) + 1;

    // CORDIC datapath width
    localparam int XW_RAW = ((ACC_W > MAG_W + 8) ? ACC_W : MAG_W + 8) + 4;
    localparam int XW     = (XW_RAW > 34) ? XW_RAW : 34;
    localparam int AW     = 33;

    localparam int TRIG_W = 32;
    localparam int KINV_W = 30;
    localparam int PW     = MAG_W + TRIG_W;
    localparam int SW     = PW + 2;
    localparam int DEPTH  = 4 * STEPS + 7;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MAG_OFFSET_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAG_OFFSET_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAG_OFFSET_Z = 2'd2;

    typedef logic signed [XW-1:0]     xw_t;
    typedef logic signed [AW-1:0]     ang_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [MAG_W-1:0]  mag_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [OFF_W-1:0]  off_t;

    typedef struct packed {
        xw_t  x;
        xw_t  y;
        ang_t z;
    } cv_t;

    typedef struct packed {
        mag_t x;
        mag_t y;
        mag_t z;
    } mag3_t;

    localparam logic [KINV_W-1:0] KINV_Q30  = 30'd652032874;
    localparam ang_t              HALF_TURN = 33'sd1179648000;
    localparam ang_t              LIM_TILT  = 33'sd9000;
    localparam ang_t              LIM_YAW   = 33'sd18000;

    // atan(2^-i) in hundredths of a degree times 2^16
    localparam ang_t ATAN_TAB [TAB_LEN] = '{
        33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
        33'sd23437865,  33'sd11730358,  33'sd5866610,  33'sd2933484,
        33'sd1466764,   33'sd733385,    33'sd366693,   33'sd183346,
        33'sd91673,     33'sd45837,     33'sd22918,    33'sd11459,
        33'sd5730,      33'sd2865,      33'sd1432,     33'sd716,
        33'sd358,       33'sd179,       33'sd90,       33'sd45
    };

    function automatic cv_t vec_step(cv_t v, int k);
        xw_t dx;
        xw_t dy;
        cv_t r;
        dx = v.y >>> k;
        dy = v.x >>> k;
        if (!v.y[XW-1])
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_TAB[TI_W'(k)];
        end
        else
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_TAB[TI_W'(k)];
        end
        return r;
    endfunction

    function automatic cv_t rot_step(cv_t v, int k);
        xw_t dx;
        xw_t dy;
        cv_t r;
        dx = v.y >>> k;
        dy = v.x >>> k;
        if (!v.z[AW-1])
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_TAB[TI_W'(k)];
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_TAB[TI_W'(k)];
        end
        return r;
    endfunction

    // round to hundredths of a degree and clamp to +-lim
    function automatic logic signed [15:0] to_cdeg(ang_t z, ang_t lim);
        ang_t r;
        r = (z + ang_t'(32768)) >>> 16;
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tilt_compensated_compass.sv =====
// Tilt-compensated compass top level: CORDIC pipeline from raw sensor
// samples to pitch, roll, yaw and heading. Depends on tcc_pkg.
//
// One transaction per clock cycle is accepted while the output is not
// stalled, and one result is given per input, in order. The pipeline is
// built from four chained CORDIC lanes of one iteration per stage: tilt
// magnitude, tilt angle, sine/cosine and yaw vectoring. A one-entry skid
// buffer at the input keeps s_axis_tready registered; it takes one more
// transaction while a result waits on m_axis. Hard-iron offsets are to be
// written through cfg_* while idle; the block itself does not enforce this.
`default_nettype none

module tilt_compensated_compass (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // acc_x, acc_y, acc_z, field_x, field_y, field_z (16 bits each)
    input  wire logic [95:0]  s_axis_tdata,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pitch_cdeg[14:0], roll_cdeg[29:15], yaw_cdeg[45:30], heading_cdeg[61:46]
    output      logic [63:0]  m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [tcc_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [tcc_pkg::OFF_W-1:0]     cfg_data
);

    typedef struct packed {
        tcc_pkg::acc_t  ax;
        tcc_pkg::acc_t  ay;
        tcc_pkg::acc_t  az;
        tcc_pkg::mag3_t m;
    } s0_t;

    typedef struct packed {
        tcc_pkg::cv_t   p;
        tcc_pkg::cv_t   r;
        tcc_pkg::acc_t  nump;
        tcc_pkg::acc_t  numr;
        tcc_pkg::mag3_t m;
    } sb_t;

    typedef struct packed {
        logic [tcc_pkg::ACC_W+tcc_pkg::KINV_W:0] pp;
        logic [tcc_pkg::ACC_W+tcc_pkg::KINV_W:0] pr;
        tcc_pkg::acc_t  nump;
        tcc_pkg::acc_t  numr;
        tcc_pkg::mag3_t m;
    } sc_t;

    typedef struct packed {
        tcc_pkg::cv_t   p;
        tcc_pkg::cv_t   r;
        logic           zp;
        logic           zr;
        tcc_pkg::mag3_t m;
    } sd_t;

    typedef struct packed {
        tcc_pkg::cv_t       p;
        tcc_pkg::cv_t       r;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
        tcc_pkg::mag3_t     m;
    } se_t;

    typedef struct packed {
        tcc_pkg::trig_t     cp;
        tcc_pkg::trig_t     cr;
        tcc_pkg::trig_t     sr;
        tcc_pkg::trig_t     t1;
        tcc_pkg::trig_t     t2;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
        tcc_pkg::mag3_t     m;
    } sf1_t;

    typedef struct packed {
        logic signed [tcc_pkg::PW-1:0] pa;
        logic signed [tcc_pkg::PW-1:0] pb;
        logic signed [tcc_pkg::PW-1:0] pc;
        logic signed [tcc_pkg::PW-1:0] pd;
        logic signed [tcc_pkg::PW-1:0] pe;
        logic signed [14:0]            pitch;
        logic signed [14:0]            roll;
    } sf2_t;

    typedef struct packed {
        tcc_pkg::xw_t       xa;
        tcc_pkg::xw_t       yb;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
    } sf3_t;

    typedef struct packed {
        tcc_pkg::cv_t       v;
        logic               zy;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
    } sg_t;

    localparam int N = tcc_pkg::STEPS;

    logic                        adv;
    logic                        in_acc;
    logic                        skid_full_reg;
    logic [95:0]                 skid_data_reg;
    logic [95:0]                 src_data;
    logic                        src_vld;
    logic [tcc_pkg::DEPTH-1:0]   vld_reg;
    tcc_pkg::off_t               off_x_reg;
    tcc_pkg::off_t               off_y_reg;
    tcc_pkg::off_t               off_z_reg;

    s0_t  s0_reg;
    s0_t  s0_next;
    sb_t  b_in;
    sb_t  b_reg [N];
    sc_t  c_reg;
    sc_t  c_next;
    sd_t  d_in;
    sd_t  d_reg [N];
    se_t  e_in;
    se_t  e_reg [N];
    sf1_t f1_reg;
    sf1_t f1_next;
    sf2_t f2_reg;
    sf2_t f2_next;
    sf3_t f3_reg;
    sf3_t f3_next;
    sg_t  f4_reg;
    sg_t  f4_next;
    sg_t  g_reg [N];
    logic [63:0] out_reg;
    logic [63:0] out_next;

    function automatic tcc_pkg::acc_t acc_of(logic [tcc_pkg::FIELD_W-1:0] f);
        logic [tcc_pkg::WIDE_W-1:0]            w;
        logic signed [tcc_pkg::SAMPLE_BITS-1:0] s;
        w = tcc_pkg::WIDE_W'(f);
        s = w[tcc_pkg::SAMPLE_BITS-1:0];
        return {s, 8'b0};
    endfunction

    function automatic tcc_pkg::mag_t mag_of(logic [tcc_pkg::FIELD_W-1:0] f,
                                             tcc_pkg::off_t off);
        logic [tcc_pkg::WIDE_W-1:0]            w;
        logic signed [tcc_pkg::SAMPLE_BITS-1:0] s;
        w = tcc_pkg::WIDE_W'(f);
        s = w[tcc_pkg::SAMPLE_BITS-1:0];
        return tcc_pkg::mag_t'(s) - tcc_pkg::mag_t'(off);
    endfunction

    function automatic sb_t b_step(sb_t s, int k);
        sb_t r;
        r   = s;
        r.p = tcc_pkg::vec_step(s.p, k);
        r.r = tcc_pkg::vec_step(s.r, k);
        return r;
    endfunction

    function automatic sd_t d_step(sd_t s, int k);
        sd_t r;
        r   = s;
        r.p = tcc_pkg::vec_step(s.p, k);
        r.r = tcc_pkg::vec_step(s.r, k);
        return r;
    endfunction

    function automatic se_t e_step(se_t s, int k);
        se_t r;
        r   = s;
        r.p = tcc_pkg::rot_step(s.p, k);
        r.r = tcc_pkg::rot_step(s.r, k);
        return r;
    endfunction

    function automatic sg_t g_step(sg_t s, int k);
        sg_t r;
        r   = s;
        r.v = tcc_pkg::vec_step(s.v, k);
        return r;
    endfunction

    // flow control
    assign adv           = !vld_reg[tcc_pkg::DEPTH-1] || m_axis_tready;
    assign s_axis_tready = !skid_full_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign src_data      = skid_full_reg ? skid_data_reg : s_axis_tdata;
    assign src_vld       = skid_full_reg || in_acc;
    assign m_axis_tvalid = vld_reg[tcc_pkg::DEPTH-1];
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            vld_reg       <= '0;
            off_x_reg     <= 16'sd144;
            off_y_reg     <= -16'sd123;
            off_z_reg     <= 16'sd46;
        end
        else
        begin
            if (in_acc && !adv)
            begin
                skid_full_reg <= 1'b1;
            end
            else if (adv)
            begin
                skid_full_reg <= 1'b0;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[tcc_pkg::DEPTH-2:0], src_vld};
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcc_pkg::REG_MAG_OFFSET_X: off_x_reg <= cfg_data;
                    tcc_pkg::REG_MAG_OFFSET_Y: off_y_reg <= cfg_data;
                    tcc_pkg::REG_MAG_OFFSET_Z: off_z_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && !adv)
        begin
            skid_data_reg <= s_axis_tdata;
        end
    end

    // stage 0: sample extraction and hard-iron correction
    always_comb
    begin
        s0_next.ax  = acc_of(src_data[15:0]);
        s0_next.ay  = acc_of(src_data[31:16]);
        s0_next.az  = acc_of(src_data[47:32]);
        s0_next.m.x = mag_of(src_data[63:48], off_x_reg);
        s0_next.m.y = mag_of(src_data[79:64], off_y_reg);
        s0_next.m.z = mag_of(src_data[95:80], off_z_reg);
    end

    // tilt magnitude lanes: vectoring of (|az|, ay) and (|az|, ax)
    always_comb
    begin
        b_in.p.x  = s0_reg.az[tcc_pkg::ACC_W-1] ? -tcc_pkg::xw_t'(s0_reg.az)
                                                : tcc_pkg::xw_t'(s0_reg.az);
        b_in.p.y  = tcc_pkg::xw_t'(s0_reg.ay);
        b_in.p.z  = '0;
        b_in.r.x  = b_in.p.x;
        b_in.r.y  = tcc_pkg::xw_t'(s0_reg.ax);
        b_in.r.z  = '0;
        b_in.nump = s0_reg.ax;
        b_in.numr = s0_reg.ay;
        b_in.m    = s0_reg.m;
    end

    // gain correction
    always_comb
    begin
        c_next.pp   = b_reg[N-1].p.x[tcc_pkg::ACC_W:0] * tcc_pkg::KINV_Q30;
        c_next.pr   = b_reg[N-1].r.x[tcc_pkg::ACC_W:0] * tcc_pkg::KINV_Q30;
        c_next.nump = b_reg[N-1].nump;
        c_next.numr = b_reg[N-1].numr;
        c_next.m    = b_reg[N-1].m;
    end

    // tilt angle lanes
    always_comb
    begin
        d_in.p.x = tcc_pkg::xw_t'(c_reg.pp >> tcc_pkg::KINV_W);
        d_in.p.y = tcc_pkg::xw_t'(c_reg.nump);
        d_in.p.z = '0;
        d_in.r.x = tcc_pkg::xw_t'(c_reg.pr >> tcc_pkg::KINV_W);
        d_in.r.y = tcc_pkg::xw_t'(c_reg.numr);
        d_in.r.z = '0;
        d_in.zp  = (d_in.p.x == '0) && (c_reg.nump == '0);
        d_in.zr  = (d_in.r.x == '0) && (c_reg.numr == '0);
        d_in.m   = c_reg.m;
    end

    // sine/cosine lanes
    always_comb
    begin
        e_in.p.x   = tcc_pkg::xw_t'(tcc_pkg::KINV_Q30);
        e_in.p.y   = '0;
        e_in.p.z   = d_reg[N-1].zp ? '0 : d_reg[N-1].p.z;
        e_in.r.x   = tcc_pkg::xw_t'(tcc_pkg::KINV_Q30);
        e_in.r.y   = '0;
        e_in.r.z   = d_reg[N-1].zr ? '0 : d_reg[N-1].r.z;
        e_in.pitch = 15'(tcc_pkg::to_cdeg(e_in.p.z, tcc_pkg::LIM_TILT));
        e_in.roll  = 15'(tcc_pkg::to_cdeg(e_in.r.z, tcc_pkg::LIM_TILT));
        e_in.m     = d_reg[N-1].m;
    end

    // cross products of the trig terms
    always_comb
    begin
        tcc_pkg::trig_t     sp;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        sp             = tcc_pkg::trig_t'(e_reg[N-1].p.y);
        f1_next.cp     = tcc_pkg::trig_t'(e_reg[N-1].p.x);
        f1_next.cr     = tcc_pkg::trig_t'(e_reg[N-1].r.x);
        f1_next.sr     = tcc_pkg::trig_t'(e_reg[N-1].r.y);
        p1             = sp * f1_next.sr;
        p2             = f1_next.cr * sp;
        f1_next.t1     = p1[61:30];
        f1_next.t2     = p2[61:30];
        f1_next.pitch  = e_reg[N-1].pitch;
        f1_next.roll   = e_reg[N-1].roll;
        f1_next.m      = e_reg[N-1].m;
    end

    // field rotation products
    always_comb
    begin
        f2_next.pa    = f1_reg.m.x * f1_reg.cp;
        f2_next.pb    = f1_reg.m.y * f1_reg.t1;
        f2_next.pc    = f1_reg.m.z * f1_reg.t2;
        f2_next.pd    = f1_reg.m.y * f1_reg.cr;
        f2_next.pe    = f1_reg.m.z * f1_reg.sr;
        f2_next.pitch = f1_reg.pitch;
        f2_next.roll  = f1_reg.roll;
    end

    always_comb
    begin
        logic signed [tcc_pkg::SW-1:0] a;
        logic signed [tcc_pkg::SW-1:0] b;
        a = tcc_pkg::SW'(f2_reg.pa) + tcc_pkg::SW'(f2_reg.pb) + tcc_pkg::SW'(f2_reg.pc);
        b = tcc_pkg::SW'(f2_reg.pd) - tcc_pkg::SW'(f2_reg.pe);
        f3_next.xa    = tcc_pkg::xw_t'(a >>> 22);
        f3_next.yb    = -tcc_pkg::xw_t'(b >>> 22);
        f3_next.pitch = f2_reg.pitch;
        f3_next.roll  = f2_reg.roll;
    end

    // yaw vectoring pre-rotation into the right half plane
    always_comb
    begin
        f4_next.zy    = (f3_reg.xa == '0) && (f3_reg.yb == '0);
        f4_next.pitch = f3_reg.pitch;
        f4_next.roll  = f3_reg.roll;
        if (f3_reg.xa[tcc_pkg::XW-1])
        begin
            f4_next.v.x = -f3_reg.xa;
            f4_next.v.y = -f3_reg.yb;
            f4_next.v.z = f3_reg.yb[tcc_pkg::XW-1] ? -tcc_pkg::HALF_TURN
                                                   : tcc_pkg::HALF_TURN;
        end
        else
        begin
            f4_next.v.x = f3_reg.xa;
            f4_next.v.y = f3_reg.yb;
            f4_next.v.z = '0;
        end
    end

    always_comb
    begin
        tcc_pkg::ang_t      zy;
        logic signed [15:0] yaw;
        logic signed [16:0] hd;
        zy       = g_reg[N-1].zy ? '0 : g_reg[N-1].v.z;
        yaw      = tcc_pkg::to_cdeg(zy, tcc_pkg::LIM_YAW);
        hd       = 17'(yaw);
        if (yaw[15])
        begin
            hd = hd + 17'sd36000;
        end
        out_next = {2'b00, hd[15:0], yaw, g_reg[N-1].roll, g_reg[N-1].pitch};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg   <= s0_next;
            b_reg[0] <= b_step(b_in, 0);
            d_reg[0] <= d_step(d_in, 0);
            e_reg[0] <= e_step(e_in, 0);
            g_reg[0] <= g_step(f4_reg, 0);
            for (int k = 1; k < N; k++)
            begin
                b_reg[k] <= b_step(b_reg[k-1], k);
                d_reg[k] <= d_step(d_reg[k-1], k);
                e_reg[k] <= e_step(e_reg[k-1], k);
                g_reg[k] <= g_step(g_reg[k-1], k);
            end
            c_reg    <= c_next;
            f1_reg   <= f1_next;
            f2_reg   <= f2_next;
            f3_reg   <= f3_next;
            f4_reg   <= f4_next;
            out_reg  <= out_next;
        end
    end

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !adv) |=> skid_full_reg)
        else $error("skid buffer missed a stalled transaction");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[61:46] < 16'd36000))
        else $error("heading out of range");

    a_heading_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[61:46] == m_axis_tdata[45:30])
                       || (m_axis_tdata[61:46] == 16'(m_axis_tdata[45:30] + 16'd36000))))
        else $error("heading does not match yaw");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[14:0]) <= 15'sd9000)
                       && ($signed(m_axis_tdata[14:0]) >= -15'sd9000)))
        else $error("pitch out of range");

endmodule

`default_nettype wire
